>>> sv/shl1_pkg.sv
// shared types and constants for the l1 spherical-harmonic irradiance evaluator
`default_nettype none
package shl1_pkg;

  localparam int COEFF_WIDTH = 24;
  localparam int DIR_WIDTH   = 16;
  localparam int SQ_WIDTH    = 31;
  localparam int LEN_WIDTH   = 32;
  localparam int RES_WIDTH   = 61;
  localparam int PRJ_WIDTH   = 48;
  localparam int TRM_WIDTH   = 64;
  localparam int NORM_FRAC   = 14;
  localparam int NORM_STEPS  = NORM_FRAC + 1;
  localparam int Q_WIDTH     = NORM_FRAC + 1;
  localparam int N_WIDTH     = NORM_FRAC + 2;
  localparam int PROD_WIDTH  = COEFF_WIDTH + N_WIDTH;
  localparam int ACC_WIDTH   = PROD_WIDTH + 2;
  localparam int OUT_WIDTH   = 23;
  localparam int CH_WIDTH    = 2;

  localparam logic [Q_WIDTH-1:0]   NORM_ONE = Q_WIDTH'(1) << NORM_FRAC;
  localparam logic [OUT_WIDTH-1:0] OUT_MAX  = {OUT_WIDTH{1'b1}};

  // side payload carried alongside the normalizer
  typedef struct packed {
    logic                          zero_dir;
    logic                          neg_x;
    logic                          neg_y;
    logic                          neg_z;
    logic signed [COEFF_WIDTH-1:0] c0;
    logic signed [COEFF_WIDTH-1:0] cx;
    logic signed [COEFF_WIDTH-1:0] cy;
    logic signed [COEFF_WIDTH-1:0] cz;
    logic [CH_WIDTH-1:0]           ch;
  } side_t;

endpackage
`default_nettype wire

>>> sv/shl1_norm_unit.sv
// pipelined bit-by-bit search for one rounded normal component magnitude
`default_nettype none
module shl1_norm_unit (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [shl1_pkg::LEN_WIDTH-1:0] len2,
  input  wire logic [shl1_pkg::SQ_WIDTH-1:0]  mag2,
  output logic      [shl1_pkg::Q_WIDTH-1:0]   q_out
);
  import shl1_pkg::*;

  // one register stage per result bit, msb first
  logic [RES_WIDTH-1:0] d_r [NORM_STEPS];
  logic [PRJ_WIDTH-1:0] p_r [NORM_STEPS];
  logic [LEN_WIDTH-1:0] l_r [NORM_STEPS];
  logic [Q_WIDTH-1:0]   q_r [NORM_STEPS];

  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_step
    localparam int SH = NORM_FRAC - k;
    logic [RES_WIDTH-1:0] d_in, d_nxt;
    logic [PRJ_WIDTH-1:0] p_in, p_nxt;
    logic [LEN_WIDTH-1:0] l_in;
    logic [Q_WIDTH-1:0]   q_in, q_nxt;
    logic [TRM_WIDTH-1:0] p_w, l_w, t, t_full;
    logic                 ok;

    // stage inputs: residual mag2 * 2^30 minus (2q)^2 * len2, and 2q * len2
    if (k == 0) begin : g_first
      assign d_in = {mag2, 30'b0};
      assign p_in = '0;
      assign l_in = len2;
      assign q_in = '0;
    end else begin : g_next
      assign d_in = d_r[k-1];
      assign p_in = p_r[k-1];
      assign l_in = l_r[k-1];
      assign q_in = q_r[k-1];
    end

    // test term len2 * ((2c-1)^2 - (2q)^2), residual step len2 * ((2c)^2 - (2q)^2)
    // a residual that would go below zero is held at zero, no later bit can pass then
    always_comb begin
      p_w    = TRM_WIDTH'(p_in);
      l_w    = TRM_WIDTH'(l_in);
      t      = (p_w << (SH + 2)) - (p_w << 1) + (l_w << (2 * SH + 2)) - (l_w << (SH + 2)) + l_w;
      t_full = (p_w << (SH + 2)) + (l_w << (2 * SH + 2));
      ok     = (t <= TRM_WIDTH'(d_in)) && !q_in[NORM_FRAC];
      if (ok) begin
        d_nxt = (t_full <= TRM_WIDTH'(d_in)) ? d_in - t_full[RES_WIDTH-1:0] : '0;
      end else begin
        d_nxt = d_in;
      end
      p_nxt = ok ? p_in + PRJ_WIDTH'(l_w << (SH + 1)) : p_in;
      q_nxt = ok ? (q_in | (Q_WIDTH'(1) << SH)) : q_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[k] <= d_nxt;
        p_r[k] <= p_nxt;
        l_r[k] <= l_in;
        q_r[k] <= q_nxt;
      end
    end
  end

  assign q_out = q_r[NORM_STEPS-1];

endmodule
`default_nettype wire

>>> sv/sh_l1_irradiance_eval_top.sv
// top level of the l1 spherical-harmonic irradiance evaluator
`default_nettype none
// Evaluates first-order spherical-harmonic irradiance for one colour channel per word:
// the direction is normalized to Q2.14 (rounded to nearest, zero direction taken as +y),
// dotted with the linear coefficients, added to the constant term and clamped to an
// unsigned Q11.12 result. One word is accepted per cycle while the pipeline moves; a word
// passes through the input, square and length stages, the 15-stage normalizer, one
// stage per result bit, and the sign, product, sum and output stages. The whole
// pipeline halts while a finished result is stalled at the output.
module sh_l1_irradiance_eval_top (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic signed [shl1_pkg::DIR_WIDTH-1:0]   in_dir_x,
  input  wire logic signed [shl1_pkg::DIR_WIDTH-1:0]   in_dir_y,
  input  wire logic signed [shl1_pkg::DIR_WIDTH-1:0]   in_dir_z,
  input  wire logic signed [shl1_pkg::COEFF_WIDTH-1:0] in_constant_coeff,
  input  wire logic signed [shl1_pkg::COEFF_WIDTH-1:0] in_coeff_x,
  input  wire logic signed [shl1_pkg::COEFF_WIDTH-1:0] in_coeff_y,
  input  wire logic signed [shl1_pkg::COEFF_WIDTH-1:0] in_coeff_z,
  input  wire logic        [shl1_pkg::CH_WIDTH-1:0]    in_channel_in,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic             [shl1_pkg::OUT_WIDTH-1:0]   out_irradiance_value,
  output logic             [shl1_pkg::CH_WIDTH-1:0]    out_channel_out
);
  import shl1_pkg::*;

  logic en;

  logic                        v1_r;
  logic signed [DIR_WIDTH-1:0] dx_r, dy_r, dz_r;
  side_t                       s1_r;

  logic                 v2_r;
  logic [SQ_WIDTH-1:0]  sqx_r, sqy_r, sqz_r;
  side_t                s2_r;
  logic signed [2*DIR_WIDTH-1:0] sqx_w, sqy_w, sqz_w;

  logic                 v3_r;
  logic [LEN_WIDTH-1:0] len_r;
  logic [SQ_WIDTH-1:0]  mx_r, my_r, mz_r;
  side_t                s3_r;
  side_t                s3_nxt;
  logic [LEN_WIDTH-1:0] len_nxt;

  logic                 vd_r [NORM_STEPS];
  side_t                sd_r [NORM_STEPS];
  logic [Q_WIDTH-1:0]   qx, qy, qz;

  logic                      v4_r;
  logic signed [N_WIDTH-1:0] nx_r, ny_r, nz_r;
  side_t                     s4_r;
  logic signed [N_WIDTH-1:0] nx_nxt, ny_nxt, nz_nxt;

  logic                         v5_r;
  logic signed [PROD_WIDTH-1:0] px_r, py_r, pz_r;
  logic signed [COEFF_WIDTH-1:0] c0_5_r;
  logic [CH_WIDTH-1:0]          ch5_r;

  logic                        v6_r;
  logic signed [ACC_WIDTH-1:0] acc_r;
  logic [CH_WIDTH-1:0]         ch6_r;
  logic signed [ACC_WIDTH-1:0] acc_nxt;

  logic                 out_valid_r;
  logic [OUT_WIDTH-1:0] val_r, val_nxt;
  logic [CH_WIDTH-1:0]  ch_out_r;
  logic signed [ACC_WIDTH-1:0] shifted;

  // whole pipeline moves unless a result waits at the output
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // input register
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r      <= in_dir_x;
      dy_r      <= in_dir_y;
      dz_r      <= in_dir_z;
      s1_r.zero_dir <= 1'b0;
      s1_r.neg_x    <= in_dir_x[DIR_WIDTH-1];
      s1_r.neg_y    <= in_dir_y[DIR_WIDTH-1];
      s1_r.neg_z    <= in_dir_z[DIR_WIDTH-1];
      s1_r.c0       <= in_constant_coeff;
      s1_r.cx       <= in_coeff_x;
      s1_r.cy       <= in_coeff_y;
      s1_r.cz       <= in_coeff_z;
      s1_r.ch       <= in_channel_in;
    end
  end

  // squared components
  assign sqx_w = dx_r * dx_r;
  assign sqy_w = dy_r * dy_r;
  assign sqz_w = dz_r * dz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= sqx_w[SQ_WIDTH-1:0];
      sqy_r <= sqy_w[SQ_WIDTH-1:0];
      sqz_r <= sqz_w[SQ_WIDTH-1:0];
      s2_r  <= s1_r;
    end
  end

  // squared length and zero-direction flag
  assign len_nxt = LEN_WIDTH'(sqx_r) + LEN_WIDTH'(sqy_r) + LEN_WIDTH'(sqz_r);
  always_comb begin
    s3_nxt          = s2_r;
    s3_nxt.zero_dir = (len_nxt == '0);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      len_r <= len_nxt;
      mx_r  <= sqx_r;
      my_r  <= sqy_r;
      mz_r  <= sqz_r;
      s3_r  <= s3_nxt;
    end
  end

  // normalizers, one per component
  shl1_norm_unit u_norm_x (.clk(clk), .en(en), .len2(len_r), .mag2(mx_r), .q_out(qx));
  shl1_norm_unit u_norm_y (.clk(clk), .en(en), .len2(len_r), .mag2(my_r), .q_out(qy));
  shl1_norm_unit u_norm_z (.clk(clk), .en(en), .len2(len_r), .mag2(mz_r), .q_out(qz));

  // side payload delay line matching the normalizer
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= s3_r;
      for (int i = 1; i < NORM_STEPS; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  // signed normal with zero-direction override
  always_comb begin
    if (sd_r[NORM_STEPS-1].zero_dir) begin
      nx_nxt = '0;
      ny_nxt = N_WIDTH'(NORM_ONE);
      nz_nxt = '0;
    end else begin
      nx_nxt = sd_r[NORM_STEPS-1].neg_x ? -N_WIDTH'(qx) : N_WIDTH'(qx);
      ny_nxt = sd_r[NORM_STEPS-1].neg_y ? -N_WIDTH'(qy) : N_WIDTH'(qy);
      nz_nxt = sd_r[NORM_STEPS-1].neg_z ? -N_WIDTH'(qz) : N_WIDTH'(qz);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nx_r <= nx_nxt;
      ny_r <= ny_nxt;
      nz_r <= nz_nxt;
      s4_r <= sd_r[NORM_STEPS-1];
    end
  end

  // linear term products
  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= s4_r.cx * nx_r;
      py_r   <= s4_r.cy * ny_r;
      pz_r   <= s4_r.cz * nz_r;
      c0_5_r <= s4_r.c0;
      ch5_r  <= s4_r.ch;
    end
  end

  // sum in Q.26
  assign acc_nxt = ACC_WIDTH'($signed({c0_5_r, {NORM_FRAC{1'b0}}})) + ACC_WIDTH'(px_r)
                 + ACC_WIDTH'(py_r) + ACC_WIDTH'(pz_r);
  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      ch6_r <= ch5_r;
    end
  end

  // floor shift, clamp at zero, saturate at top
  always_comb begin
    shifted = acc_r >>> NORM_FRAC;
    if (acc_r <= 0) begin
      val_nxt = '0;
    end else if (shifted > ACC_WIDTH'(OUT_MAX)) begin
      val_nxt = OUT_MAX;
    end else begin
      val_nxt = shifted[OUT_WIDTH-1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      val_r    <= val_nxt;
      ch_out_r <= ch6_r;
    end
  end

  // valid bits along the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NORM_STEPS; i++) begin
        vd_r[i] <= 1'b0;
      end
    end else if (en) begin
      v1_r    <= in_valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      vd_r[0] <= v3_r;
      for (int i = 1; i < NORM_STEPS; i++) begin
        vd_r[i] <= vd_r[i-1];
      end
      v4_r        <= vd_r[NORM_STEPS-1];
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_irradiance_value = val_r;
  assign out_channel_out      = ch_out_r;

endmodule
`default_nettype wire
